// ===== hdl/csfw_pkg.sv =====
package csfw_pkg;

	// operation codes
	localparam logic OP_WAIT   = 1'b0;
	localparam logic OP_SIGNAL = 1'b1;

	// largest count a semaphore can reach
	localparam int COUNT_TOP = 31;

	typedef struct packed {
		logic       operation;
		logic [3:0] sem_index;
		logic [3:0] process_id;
	} req_item_t;

	typedef struct packed {
		logic       granted;
		logic       blocked;
		logic       woke_valid;
		logic [3:0] woke_process;
		logic       queue_error;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WAKE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic commit;
		logic rsp_load_lookup;
		logic rsp_load_wake;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_wake;
	} dp_status_t;

endpackage

// ===== hdl/csfw_ram.sv =====
module csfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/csfw_ctrl.sv =====
module csfw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output csfw_pkg::ctrl_cmd_t    cmd,
	input  csfw_pkg::dp_status_t   status
);

	csfw_pkg::ctrl_state_t state_q;
	csfw_pkg::ctrl_state_t state_nxt;
	logic                  rsp_valid_q;
	logic                  rsp_free;

	// output slot can take a new result this cycle
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			csfw_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = csfw_pkg::ST_LOOKUP;
				end
			end
			csfw_pkg::ST_LOOKUP: begin
				if (rsp_free) begin
					state_nxt = status.need_wake ? csfw_pkg::ST_WAKE : csfw_pkg::ST_IDLE;
				end
			end
			csfw_pkg::ST_WAKE: begin
				if (rsp_free) begin
					state_nxt = csfw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = csfw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			csfw_pkg::ST_IDLE: begin
				req_stall     = 1'b0;
				cmd.load_item = req_valid;
			end
			csfw_pkg::ST_LOOKUP: begin
				cmd.commit          = rsp_free;
				cmd.rsp_load_lookup = rsp_free && !status.need_wake;
			end
			csfw_pkg::ST_WAKE: begin
				cmd.rsp_load_wake = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csfw_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.rsp_load_lookup || cmd.rsp_load_wake) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hdl/csfw_dp.sv =====
module csfw_dp #(
	parameter int NUM_SEMS  = 10,
	parameter int MAX_PROCS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csfw_pkg::req_item_t    req,
	output csfw_pkg::rsp_item_t    rsp,
	input  csfw_pkg::ctrl_cmd_t    cmd,
	output csfw_pkg::dp_status_t   status
);

	localparam int SEM_AW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int HW       = $clog2(MAX_PROCS);
	localparam int WW       = HW + 1;
	localparam int CW       = (HW + 1 > 6) ? HW + 1 : 6;
	localparam int ST_DEPTH = NUM_SEMS * MAX_PROCS;
	localparam int ST_AW    = $clog2(ST_DEPTH);
	localparam logic signed [CW-1:0] CNT_TOP = CW'(csfw_pkg::COUNT_TOP);
	localparam logic signed [CW-1:0] CNT_ONE = CW'(1);
	localparam logic [WW-1:0]        WAIT_MAX = WW'(MAX_PROCS);

	// latched transaction
	logic              op_q;
	logic [SEM_AW-1:0] si_q;
	logic [3:0]        pid_q;
	logic              oob_q;
	logic              sem_vld_rd_q;
	logic [NUM_SEMS-1:0] sem_vld_q;
	logic              oob_in;

	// count/head memory
	logic [CW+HW-1:0] sem_rd_data;
	logic [CW+HW-1:0] sem_wr_data;

	// wait id memory
	logic             st_wr_en;
	logic             st_rd_en;
	logic [ST_AW-1:0] st_base;
	logic [ST_AW-1:0] st_addr;
	logic [3:0]       st_rd_data;

	logic signed [CW-1:0] cnt;
	logic signed [CW-1:0] cnt_dec;
	logic signed [CW-1:0] cnt_inc;
	logic signed [CW-1:0] cnt_new;
	logic [HW-1:0]        head;
	logic [HW-1:0]        head_inc;
	logic [HW-1:0]        head_new;
	logic [WW-1:0]        waiters;
	logic [HW:0]          tail_sum;
	logic [HW-1:0]        tail;
	logic                 is_wait;
	logic                 full;
	logic                 blocks;
	logic                 at_top;
	logic                 wake;

	csfw_pkg::rsp_item_t lookup_rsp;
	csfw_pkg::rsp_item_t wake_rsp;
	csfw_pkg::rsp_item_t rsp_q;

	assign oob_in = 32'(req.sem_index) >= 32'(NUM_SEMS);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q         <= req.operation;
			si_q         <= SEM_AW'(req.sem_index);
			pid_q        <= req.process_id;
			oob_q        <= oob_in;
			sem_vld_rd_q <= oob_in ? 1'b0 : sem_vld_q[SEM_AW'(req.sem_index)];
		end
	end

	// a semaphore never written reads as count one, head zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sem_vld_q <= '0;
		end else if (cmd.commit && !oob_q) begin
			sem_vld_q[si_q] <= 1'b1;
		end
	end

	csfw_ram #(
		.WIDTH(CW + HW),
		.DEPTH(NUM_SEMS)
	) u_sem_ram (
		.clk    (clk),
		.wr_en  (cmd.commit && !oob_q),
		.wr_addr(si_q),
		.wr_data(sem_wr_data),
		.rd_en  (cmd.load_item),
		.rd_addr(SEM_AW'(req.sem_index)),
		.rd_data(sem_rd_data)
	);

	always_comb begin
		cnt     = sem_vld_rd_q ? sem_rd_data[CW+HW-1:HW] : CNT_ONE;
		head    = sem_vld_rd_q ? sem_rd_data[HW-1:0] : '0;
		is_wait = (op_q == csfw_pkg::OP_WAIT);
		waiters = cnt[CW-1] ? WW'(-cnt) : '0;
		full    = waiters >= WAIT_MAX;
		cnt_dec = cnt - CNT_ONE;
		cnt_inc = cnt + CNT_ONE;
		blocks  = cnt_dec[CW-1];
		at_top  = cnt >= CNT_TOP;
		wake    = !at_top && cnt[CW-1];
		// slot behind the last waiter, wrapped once
		tail_sum = (HW+1)'(head) + (HW+1)'(waiters);
		tail     = (tail_sum >= (HW+1)'(MAX_PROCS)) ? HW'(tail_sum - (HW+1)'(MAX_PROCS))
		                                           : HW'(tail_sum);
		head_inc = (32'(head) + 32'd1 == 32'(MAX_PROCS)) ? '0 : head + HW'(1);

		cnt_new  = cnt;
		head_new = head;
		if (is_wait) begin
			if (!full) begin
				cnt_new = cnt_dec;
			end
		end else if (!at_top) begin
			cnt_new = cnt_inc;
			if (wake) begin
				head_new = head_inc;
			end
		end
		sem_wr_data = {cnt_new, head_new};

		lookup_rsp             = '0;
		lookup_rsp.granted     = !oob_q && is_wait && !full && !blocks;
		lookup_rsp.blocked     = !oob_q && is_wait && !full && blocks;
		lookup_rsp.queue_error = !oob_q && is_wait && full;

		wake_rsp              = '0;
		wake_rsp.woke_valid   = 1'b1;
		wake_rsp.woke_process = st_rd_data;
	end

	assign status.need_wake = !oob_q && !is_wait && wake;

	assign st_wr_en = cmd.commit && !oob_q && is_wait && !full && blocks;
	assign st_rd_en = cmd.commit && status.need_wake;
	assign st_base  = ST_AW'(32'(si_q) * MAX_PROCS);
	assign st_addr  = st_base + ST_AW'(is_wait ? tail : head);

	csfw_ram #(
		.WIDTH(4),
		.DEPTH(ST_DEPTH)
	) u_wait_ram (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(st_addr),
		.wr_data(pid_q),
		.rd_en  (st_rd_en),
		.rd_addr(st_addr),
		.rd_data(st_rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.rsp_load_lookup) begin
			rsp_q <= lookup_rsp;
		end else if (cmd.rsp_load_wake) begin
			rsp_q <= wake_rsp;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== hdl/counting_semaphore_fifo_wait.sv =====
// bank of counting semaphores, each with a fifo of blocked process ids
//
// request channel (req_valid / req_stall / req): one transaction is a wait or
// a signal on one semaphore, taken when req_valid is high and req_stall low.
// response channel (rsp_valid / rsp_stall / rsp): exactly one response per
// request, in request order, held stable while rsp_stall is high.
//
// the controller handles one request at a time, in steps: read the
// semaphore's count/head memory, update it, and, for a request that wakes a
// waiter, read the woken id from the wait-id memory.
// a finished response sits in the output register while the next request is
// taken; if rsp_stall holds it there, the following request waits at its
// update step until the slot frees.
// reset: every semaphore reads as count 1 with an empty queue right away
// (per-semaphore valid flags); no clearing pass is needed.
module counting_semaphore_fifo_wait #(
	parameter int NUM_SEMS  = 10,
	parameter int MAX_PROCS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  csfw_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output csfw_pkg::rsp_item_t rsp
);

	// command and status between sequencer and datapath
	csfw_pkg::ctrl_cmd_t  cmd;
	csfw_pkg::dp_status_t status;

	// sequencer: idle -> lookup -> (wake) -> idle
	csfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// count/head memory, wait-id memory and the response register
	csfw_dp #(
		.NUM_SEMS (NUM_SEMS),
		.MAX_PROCS(MAX_PROCS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.status(status)
	);

endmodule
